/* rtl/rg_chroma_skin_classifier_assert.svh */
// Assertion macros shared by the skin classifier checker.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef RG_CHROMA_SKIN_CLASSIFIER_ASSERT_SVH
`define RG_CHROMA_SKIN_CLASSIFIER_ASSERT_SVH

// Property checked outside reset
`define RGCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included
`define RGCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rgcs_pkg.sv */
// Types and constants of the normalized-rg skin classifier.
// No dependencies; used by the interfaces and the top level.
package rgcs_pkg;

  // Configuration register indexes
  typedef enum logic [3:0] {
    REG_UPPER_QUAD  = 4'd0,
    REG_UPPER_LIN   = 4'd1,
    REG_UPPER_CONST = 4'd2,
    REG_LOWER_QUAD  = 4'd3,
    REG_LOWER_LIN   = 4'd4,
    REG_LOWER_CONST = 4'd5,
    REG_WHITE_CTR   = 4'd6,
    REG_WHITE_THR   = 4'd7
  } cfg_reg_t;

  localparam int CFG_DATA_W = 32;
  localparam int COEF_W     = 16;
  localparam int CTR_W      = 15;
  localparam int THR_W      = 29;

  // Reset values (Q2.14 curves, Q1.14 center, Q1.28 squared radius)
  localparam logic signed [COEF_W-1:0] UPPER_QUAD_RST  = -16'sd30184;
  localparam logic signed [COEF_W-1:0] UPPER_LIN_RST   = 16'sd26090;
  localparam logic signed [COEF_W-1:0] UPPER_CONST_RST = 16'sd691;
  localparam logic signed [COEF_W-1:0] LOWER_QUAD_RST  = -16'sd11926;
  localparam logic signed [COEF_W-1:0] LOWER_LIN_RST   = 16'sd9939;
  localparam logic signed [COEF_W-1:0] LOWER_CONST_RST = 16'sd2893;
  localparam logic [CTR_W-1:0]         WHITE_CTR_RST   = 15'd5407;
  localparam logic [THR_W-1:0]         WHITE_THR_RST   = 29'd1073742;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic       skin_flag;
    logic [7:0] fore_red;
    logic [7:0] fore_green;
    logic [7:0] fore_blue;
    logic [7:0] back_red;
    logic [7:0] back_green;
    logic [7:0] back_blue;
  } result_t;

  typedef struct packed {
    logic [3:0]            index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

endpackage

/* rtl/rgcs_ifs.sv */
// Valid/ready channel interfaces: pixel in, result out, register write.
// Depends on rgcs_pkg for the payload types.
interface rgcs_pix_if import rgcs_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rgcs_res_if import rgcs_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rgcs_cfg_if import rgcs_pkg::*; ();
  logic    valid;
  logic    ready;
  cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/rg_chroma_skin_classifier.sv */
// Channel   Dir  Payload                            Beat when
// in_ch     in   red, green, blue                   valid & ready
// out_ch    out  skin_flag, fore_*, back_*          valid & ready
// cfg_ch    in   index, wdata (8 registers)         valid & ready (ready tied high)
//
// Five register stages; one pixel per clock while out_ch does not stall.
// The stages follow the multiply chain: s, products of s, coefficient
// products and white offsets, curve sums and squares, then the three compares.
// Reset (rst_n low, synchronous) empties the pipe and loads default registers.
// Each stage holds when full and blocked; bubbles still fill under a stall.
// Depends on rgcs_pkg and the interfaces in rgcs_ifs.sv.
module rg_chroma_skin_classifier import rgcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rgcs_pix_if.sink  in_ch,
  rgcs_res_if.source out_ch,
  rgcs_cfg_if.sink  cfg_ch
);

  // Configuration registers
  logic signed [COEF_W-1:0] upper_quad_r, upper_lin_r, upper_const_r;
  logic signed [COEF_W-1:0] lower_quad_r, lower_lin_r, lower_const_r;
  logic [CTR_W-1:0]         white_ctr_r;
  logic [THR_W-1:0]         white_thr_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_quad_r  <= UPPER_QUAD_RST;
      upper_lin_r   <= UPPER_LIN_RST;
      upper_const_r <= UPPER_CONST_RST;
      lower_quad_r  <= LOWER_QUAD_RST;
      lower_lin_r   <= LOWER_LIN_RST;
      lower_const_r <= LOWER_CONST_RST;
      white_ctr_r   <= WHITE_CTR_RST;
      white_thr_r   <= WHITE_THR_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.data.index))
        REG_UPPER_QUAD:  upper_quad_r  <= cfg_ch.data.wdata[COEF_W-1:0];
        REG_UPPER_LIN:   upper_lin_r   <= cfg_ch.data.wdata[COEF_W-1:0];
        REG_UPPER_CONST: upper_const_r <= cfg_ch.data.wdata[COEF_W-1:0];
        REG_LOWER_QUAD:  lower_quad_r  <= cfg_ch.data.wdata[COEF_W-1:0];
        REG_LOWER_LIN:   lower_lin_r   <= cfg_ch.data.wdata[COEF_W-1:0];
        REG_LOWER_CONST: lower_const_r <= cfg_ch.data.wdata[COEF_W-1:0];
        REG_WHITE_CTR:   white_ctr_r   <= cfg_ch.data.wdata[CTR_W-1:0];
        REG_WHITE_THR:   white_thr_r   <= cfg_ch.data.wdata[THR_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Stage valids and per-stage ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_r || out_ch.ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage 1: capture pixel, channel sum s
  pixel_t     pix1_r;
  logic [9:0] s1_r;
  logic [9:0] s1_nxt;

  assign s1_nxt = {2'b00, in_ch.data.red} + {2'b00, in_ch.data.green}
                + {2'b00, in_ch.data.blue};

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      pix1_r <= in_ch.data;
      s1_r   <= s1_nxt;
    end
  end

  // Stage 2: r*r, r*s, s*s, g*s, W*s
  pixel_t      pix2_r;
  logic [15:0] rr2_r, rr2_nxt;
  logic [17:0] rs2_r, rs2_nxt;
  logic [19:0] ss2_r, ss2_nxt;
  logic [17:0] gs2_r, gs2_nxt;
  logic [24:0] ws2_r, ws2_nxt;

  assign rr2_nxt = pix1_r.red * pix1_r.red;
  assign rs2_nxt = pix1_r.red * s1_r;
  assign ss2_nxt = s1_r * s1_r;
  assign gs2_nxt = pix1_r.green * s1_r;
  assign ws2_nxt = white_ctr_r * s1_r;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      pix2_r <= pix1_r;
      rr2_r  <= rr2_nxt;
      rs2_r  <= rs2_nxt;
      ss2_r  <= ss2_nxt;
      gs2_r  <= gs2_nxt;
      ws2_r  <= ws2_nxt;
    end
  end

  // Stage 3: coefficient products, white offsets, threshold * s*s
  pixel_t             pix3_r;
  logic [17:0]        gs3_r;
  logic signed [32:0] ua3_r, ua3_nxt, la3_r, la3_nxt;
  logic signed [34:0] ub3_r, ub3_nxt, lb3_r, lb3_nxt;
  logic signed [36:0] uc3_r, uc3_nxt, lc3_r, lc3_nxt;
  logic signed [25:0] dr3_r, dr3_nxt, dg3_r, dg3_nxt;
  logic [48:0]        thr3_r, thr3_nxt;

  assign ua3_nxt = upper_quad_r  * $signed({1'b0, rr2_r});
  assign ub3_nxt = upper_lin_r   * $signed({1'b0, rs2_r});
  assign uc3_nxt = upper_const_r * $signed({1'b0, ss2_r});
  assign la3_nxt = lower_quad_r  * $signed({1'b0, rr2_r});
  assign lb3_nxt = lower_lin_r   * $signed({1'b0, rs2_r});
  assign lc3_nxt = lower_const_r * $signed({1'b0, ss2_r});
  assign dr3_nxt = $signed({4'b0, pix2_r.red, 14'b0}) - $signed({1'b0, ws2_r});
  assign dg3_nxt = $signed({4'b0, pix2_r.green, 14'b0}) - $signed({1'b0, ws2_r});
  assign thr3_nxt = white_thr_r * ss2_r;

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      pix3_r <= pix2_r;
      gs3_r  <= gs2_r;
      ua3_r  <= ua3_nxt;
      ub3_r  <= ub3_nxt;
      uc3_r  <= uc3_nxt;
      la3_r  <= la3_nxt;
      lb3_r  <= lb3_nxt;
      lc3_r  <= lc3_nxt;
      dr3_r  <= dr3_nxt;
      dg3_r  <= dg3_nxt;
      thr3_r <= thr3_nxt;
    end
  end

  // Stage 4: curve sums, squared white offsets
  pixel_t             pix4_r;
  logic [17:0]        gs4_r;
  logic signed [37:0] up4_r, up4_nxt, lo4_r, lo4_nxt;
  logic [49:0]        dr2_4_r, dr2_4_nxt, dg2_4_r, dg2_4_nxt;
  logic [48:0]        thr4_r;

  assign up4_nxt   = ua3_r + ub3_r + uc3_r;
  assign lo4_nxt   = la3_r + lb3_r + lc3_r;
  assign dr2_4_nxt = dr3_r * dr3_r;
  assign dg2_4_nxt = dg3_r * dg3_r;

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      pix4_r  <= pix3_r;
      gs4_r   <= gs3_r;
      up4_r   <= up4_nxt;
      lo4_r   <= lo4_nxt;
      dr2_4_r <= dr2_4_nxt;
      dg2_4_r <= dg2_4_nxt;
      thr4_r  <= thr3_r;
    end
  end

  // Stage 5: compares and result register.
  // A black pixel gives zero on both sides of the curve tests, so it fails them.
  logic signed [37:0] lhs5;
  logic [50:0]        dist5;
  logic               skin5;
  result_t            res_r, res_nxt;

  assign lhs5  = $signed({6'b0, gs4_r, 14'b0});
  assign dist5 = {1'b0, dr2_4_r} + {1'b0, dg2_4_r};
  assign skin5 = (lhs5 < up4_r) && (lhs5 > lo4_r) && (dist5 > {2'b0, thr4_r});

  always_comb begin
    res_nxt.skin_flag  = skin5;
    res_nxt.fore_red   = skin5 ? pix4_r.red   : 8'd0;
    res_nxt.fore_green = skin5 ? pix4_r.green : 8'd0;
    res_nxt.fore_blue  = skin5 ? pix4_r.blue  : 8'd0;
    res_nxt.back_red   = skin5 ? 8'd0 : pix4_r.red;
    res_nxt.back_green = skin5 ? 8'd0 : pix4_r.green;
    res_nxt.back_blue  = skin5 ? 8'd0 : pix4_r.blue;
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid = v5_r;
  assign out_ch.data  = res_r;

endmodule

/* rtl/rgcs_checker.sv */
// Port-level checks of the skin classifier, bound to the top level.
// Depends on rg_chroma_skin_classifier_assert.svh and the top level's ports.
`include "rg_chroma_skin_classifier_assert.svh"

module rgcs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       skin_flag,
  input logic [7:0] fore_red,
  input logic [7:0] fore_green,
  input logic [7:0] fore_blue,
  input logic [7:0] back_red,
  input logic [7:0] back_green,
  input logic [7:0] back_blue
);

  logic [47:0] res_bits;
  assign res_bits = {fore_red, fore_green, fore_blue, back_red, back_green, back_blue};

  // Reset drains the result register
  `RGCS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

  // A stalled result holds
  `RGCS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(res_bits) && $stable(skin_flag), "stalled result changed")

  // An empty result register always lets a pixel in
  `RGCS_ASSERT(a_empty_ready, !out_valid |-> in_ready, "input blocked while output empty")

  // Skin goes to foreground only, and a black pixel is never skin
  `RGCS_ASSERT(a_split, out_valid && skin_flag |-> res_bits[23:0] == 24'd0 && res_bits[47:24] != 24'd0, "bad skin split")

endmodule

bind rg_chroma_skin_classifier rgcs_checker u_rgcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .skin_flag  (out_ch.data.skin_flag),
  .fore_red   (out_ch.data.fore_red),
  .fore_green (out_ch.data.fore_green),
  .fore_blue  (out_ch.data.fore_blue),
  .back_red   (out_ch.data.back_red),
  .back_green (out_ch.data.back_green),
  .back_blue  (out_ch.data.back_blue)
);
